// ===== src/aedg_pkg.sv =====
// ----------------------------------------------------------------------------
// aedg_pkg: shared types and constants for the AM envelope detector
// Widths, reset values and fixed-point positions used by the front end,
// the queue and the filter/gain sequencer.
// ----------------------------------------------------------------------------
package aedg_pkg;

  // Sample and fixed-point layout
  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRACTION_BITS = 15;
  localparam int MAG_W         = SAMPLE_WIDTH + 1;
  localparam int DIFF_W        = MAG_W + 1;
  localparam int Y_W           = 40;
  localparam int Y_LO_W        = Y_W / 2;
  localparam int Y_HI_W        = Y_W - Y_LO_W;
  localparam int PCM_W         = 16;

  // Coefficients
  localparam int GAIN_W    = 24;
  localparam int POLE_W    = 15;
  localparam int GAIN_FRAC = 8;
  localparam int POLE_FRAC = 15;
  localparam int OP_W      = (GAIN_W > POLE_W) ? GAIN_W : POLE_W;

  // Shared multiplier: one half of y times one coefficient
  localparam int MUL_W     = (Y_LO_W + 1) + (OP_W + 1);
  localparam int ACC_W     = Y_W + OP_W;
  localparam int SUM_W     = ACC_W - POLE_FRAC + 1;
  localparam int OUT_SHIFT = FRACTION_BITS + GAIN_FRAC;
  localparam int T_W       = ACC_W - OUT_SHIFT;

  localparam logic [ACC_W-1:0] ROUND_BIAS =
    {{(ACC_W - OUT_SHIFT){1'b0}}, {OUT_SHIFT{1'b1}}};

  // Configuration port
  localparam int CFG_DATA_W = GAIN_W;
  localparam int CFG_IDX_W  = 1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(76800);
  localparam logic [POLE_W-1:0] POLE_RESET = POLE_W'(31130);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN = 1'b0,
    REG_POLE = 1'b1
  } reg_index_t;

  // Queue between front end and sequencer
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             block_end;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== src/aedg_front.sv =====
// ----------------------------------------------------------------------------
// aedg_front: input handshake and magnitude estimate
// Takes one I/Q word, forms max(|I|,|Q|) + min(|I|,|Q|)/2 and pushes it
// with its block-end flag into the queue.
// ----------------------------------------------------------------------------
module aedg_front
  import aedg_pkg::*;
(
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] q_sample,
  input  logic                           block_end,
  input  q_status_t                      q_status,
  output logic                           push,
  output item_t                          item
);

  logic [SAMPLE_WIDTH-1:0] i_abs;
  logic [SAMPLE_WIDTH-1:0] q_abs;

  // Take absolute values; the most negative code maps to 2^(SAMPLE_WIDTH-1)
  always_comb begin
    i_abs = i_sample[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-i_sample) : i_sample;
    q_abs = q_sample[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-q_sample) : q_sample;
  end

  // Add half the smaller to the larger; ties count I as the smaller
  always_comb begin
    if (i_abs > q_abs) begin
      item.mag = {1'b0, i_abs} + {2'b00, q_abs[SAMPLE_WIDTH-1:1]};
    end else begin
      item.mag = {1'b0, q_abs} + {2'b00, i_abs[SAMPLE_WIDTH-1:1]};
    end
    item.block_end = block_end;
  end

  // Accept whenever the queue has room
  assign sample_ready = !q_status.full;
  assign push         = sample_valid && !q_status.full;

endmodule

// ===== src/aedg_queue.sv =====
// ----------------------------------------------------------------------------
// aedg_queue: short word queue between front end and sequencer
// Lets the front end keep accepting while the sequencer is busy.
// ----------------------------------------------------------------------------
module aedg_queue
  import aedg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     wr_item,
  input  logic      pop,
  output item_t     rd_item,
  output q_status_t q_status
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t            mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rd_item        = mem[rd_ptr];
  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == CNT_W'(QDEPTH));

endmodule

// ===== src/aedg_back.sv =====
// ----------------------------------------------------------------------------
// aedg_back: DC blocker and output gain sequencer
// Runs y = (m - m_prev) * 2^15 + floor(pole * y_prev / 2^15) and then
// pcm = sat16(trunc(y * gain / 2^23)) on one shared multiplier that takes
// the 40-bit y in two halves, and holds the result in the output register.
// ----------------------------------------------------------------------------
module aedg_back
  import aedg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic [GAIN_W-1:0]       gain_q8,
  input  logic [POLE_W-1:0]       pole_q15,
  input  q_status_t               q_status,
  input  item_t                   head,
  output logic                    pop,
  output logic                    pcm_valid,
  input  logic                    pcm_ready,
  output logic signed [PCM_W-1:0] pcm_sample,
  output logic                    pcm_block_end
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MLO,
    S_MHI,
    S_MSUM,
    S_Y,
    S_OUT
  } state_t;

  typedef enum logic {
    PH_FB,
    PH_GAIN
  } phase_t;

  state_t                    state;
  phase_t                    phase;
  logic [MAG_W-1:0]          prev_mag;
  logic signed [Y_W-1:0]     y_reg;
  logic signed [DIFF_W-1:0]  diff;
  logic                      be;
  logic signed [MUL_W-1:0]   prod;
  logic signed [ACC_W-1:0]   acc;

  logic [OP_W-1:0]           mul_op;
  logic signed [Y_LO_W:0]    mul_a;
  logic signed [MUL_W-1:0]   mul_p;
  logic signed [SUM_W-1:0]   y_sum;
  logic [SUM_W-Y_W:0]        y_top;
  logic signed [Y_W-1:0]     y_sat;
  logic signed [ACC_W-1:0]   acc_b;
  logic signed [T_W-1:0]     t_val;
  logic [T_W-PCM_W:0]        t_top;
  logic signed [PCM_W-1:0]   pcm_sat;
  logic                      slot_free;
  logic                      out_load;

  // Select the coefficient and the half of y for the shared multiplier
  always_comb begin
    mul_op = (phase == PH_GAIN) ? gain_q8 : {{(OP_W - POLE_W){1'b0}}, pole_q15};
    if (state == S_MHI) begin
      mul_a = {{(Y_LO_W + 1 - Y_HI_W){y_reg[Y_W-1]}}, y_reg[Y_W-1:Y_LO_W]};
    end else begin
      mul_a = $signed({1'b0, y_reg[Y_LO_W-1:0]});
    end
    mul_p = mul_a * $signed({1'b0, mul_op});
  end

  // Form the new filter output and saturate it to 40 bits
  always_comb begin
    y_sum = (SUM_W'(diff) <<< FRACTION_BITS) + SUM_W'(acc >>> POLE_FRAC);
    y_top = y_sum[SUM_W-1:Y_W-1];
    if ((&y_top) || !(|y_top)) begin
      y_sat = y_sum[Y_W-1:0];
    end else if (y_sum[SUM_W-1]) begin
      y_sat = {1'b1, {(Y_W - 1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(Y_W - 1){1'b1}}};
    end
  end

  // Truncate the scaled sample toward zero and saturate to 16 bits
  always_comb begin
    acc_b = acc + (acc[ACC_W-1] ? $signed(ROUND_BIAS) : $signed({ACC_W{1'b0}}));
    t_val = acc_b[ACC_W-1:OUT_SHIFT];
    t_top = t_val[T_W-1:PCM_W-1];
    if ((&t_top) || !(|t_top)) begin
      pcm_sat = t_val[PCM_W-1:0];
    end else if (t_val[T_W-1]) begin
      pcm_sat = {1'b1, {(PCM_W - 1){1'b0}}};
    end else begin
      pcm_sat = {1'b0, {(PCM_W - 1){1'b1}}};
    end
  end

  assign slot_free = !pcm_valid || pcm_ready;
  assign out_load  = (state == S_OUT) && slot_free;
  assign pop       = (state == S_IDLE) && !q_status.empty;

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        diff <= $signed({1'b0, head.mag}) - $signed({1'b0, prev_mag});
        be   <= head.block_end;
      end
      S_MLO: begin
        prod <= mul_p;
      end
      S_MHI: begin
        acc  <= ACC_W'(prod);
        prod <= mul_p;
      end
      S_MSUM: begin
        acc <= acc + (ACC_W'(prod) <<< Y_LO_W);
      end
      S_Y, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer state, filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_FB;
      prev_mag  <= '0;
      y_reg     <= '0;
      pcm_valid <= 1'b0;
    end else begin
      // Load a new word or drop the one just taken
      if (out_load) begin
        pcm_valid <= 1'b1;
      end else if (pcm_valid && pcm_ready) begin
        pcm_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_status.empty) begin
            prev_mag <= head.mag;
            phase    <= PH_FB;
            state    <= S_MLO;
          end
        end
        S_MLO: begin
          state <= S_MHI;
        end
        S_MHI: begin
          state <= S_MSUM;
        end
        S_MSUM: begin
          state <= (phase == PH_FB) ? S_Y : S_OUT;
        end
        S_Y: begin
          y_reg <= y_sat;
          phase <= PH_GAIN;
          state <= S_MLO;
        end
        S_OUT: begin
          if (slot_free) begin
            pcm_sample    <= pcm_sat;
            pcm_block_end <= be;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A new result appears only from the output step
  ap_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(pcm_valid) |-> $past(state) == S_OUT)
    else $error("result loaded outside the output step");

  // The previous magnitude moves only when a word is taken from the queue
  ap_mag_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(prev_mag))
    else $error("previous magnitude changed mid-item");

  // The output step is reached only after the gain pass
  ap_out_phase: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (phase == PH_GAIN))
    else $error("output step reached before gain multiply");

  // A waiting result is never overwritten
  ap_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (pcm_valid && !pcm_ready) |=> pcm_valid && $stable(pcm_sample))
    else $error("pending result overwritten");

endmodule

// ===== src/am_envelope_dc_block_gain.sv =====
// ----------------------------------------------------------------------------
// am_envelope_dc_block_gain: AM envelope detector with DC blocker and gain
// Estimates |I + jQ| as max + min/2, removes DC with a first-order IIR and
// scales the result to a saturated 16-bit PCM sample.
// ----------------------------------------------------------------------------
// Each accepted I/Q word yields exactly one PCM word, in order, with its
// block-end flag copied through. Per item the sequencer pops the queue, then
// forms the feedback product pole * y_prev in two passes of a 21 x 25 bit
// multiplier over the halves of the 40-bit filter state and an accumulate
// step, updates the filter, forms the gain product y * gain the same way and
// loads the output register. A two-word queue sits between the input
// and the sequencer, so up to two further words are taken while one is
// being worked on, and a finished word waits in the output register without
// stopping the sequencer's next pop. Configuration writes take effect at
// once and are meant to be issued only while the block is idle; gain_q8
// (index 0) resets to 300.0 and pole_q15 (index 1) to about 0.95.
// ----------------------------------------------------------------------------
module am_envelope_dc_block_gain
  import aedg_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] q_sample,
  input  logic                           block_end,
  output logic                           pcm_valid,
  input  logic                           pcm_ready,
  output logic signed [PCM_W-1:0]        pcm_sample,
  output logic                           pcm_block_end
);

  logic [GAIN_W-1:0] gain_q8;
  logic [POLE_W-1:0] pole_q15;
  q_status_t         q_status;
  item_t             wr_item;
  item_t             head;
  logic              push;
  logic              pop;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q8  <= GAIN_RESET;
      pole_q15 <= POLE_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_GAIN: gain_q8  <= cfg_data[GAIN_W-1:0];
        REG_POLE: pole_q15 <= cfg_data[POLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  aedg_front u_front (
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .i_sample     (i_sample),
    .q_sample     (q_sample),
    .block_end    (block_end),
    .q_status     (q_status),
    .push         (push),
    .item         (wr_item)
  );

  aedg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_item  (wr_item),
    .pop      (pop),
    .rd_item  (head),
    .q_status (q_status)
  );

  aedg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .gain_q8       (gain_q8),
    .pole_q15      (pole_q15),
    .q_status      (q_status),
    .head          (head),
    .pop           (pop),
    .pcm_valid     (pcm_valid),
    .pcm_ready     (pcm_ready),
    .pcm_sample    (pcm_sample),
    .pcm_block_end (pcm_block_end)
  );

endmodule

// ===== bench/tb_am_envelope_dc_block_gain.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_am_envelope_dc_block_gain: self-checking bench for the AM envelope block
// Drives I/Q words through valid/ready with random gaps on both sides. A
// local model of the magnitude estimate, DC blocker and gain stage predicts
// every PCM word, and each word leaving the block is checked field by field.
// ----------------------------------------------------------------------------
module tb_am_envelope_dc_block_gain;
  import aedg_pkg::*;

  localparam int     CLK_PERIOD   = 8;
  localparam int     RESET_CYCLES = 6;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     DRAIN_CYCLES = 24;
  localparam int     MAX_REPORTS  = 10;
  localparam longint Y_MAX        = (longint'(1) <<< (Y_W - 1)) - 1;
  localparam longint Y_MIN        = -Y_MAX - 1;

  typedef struct {
    logic signed [PCM_W-1:0] pcm;
    logic                    blk_end;
  } pcm_word_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]           cfg_index = '0;
  logic [CFG_DATA_W-1:0]          cfg_data = '0;
  logic                           sample_valid = 1'b0;
  logic                           sample_ready;
  logic signed [SAMPLE_WIDTH-1:0] i_sample = '0;
  logic signed [SAMPLE_WIDTH-1:0] q_sample = '0;
  logic                           block_end = 1'b0;
  logic                           pcm_valid;
  logic                           pcm_ready = 1'b0;
  logic signed [PCM_W-1:0]        pcm_sample;
  logic                           pcm_block_end;

  // Model state and register copies
  logic [GAIN_W-1:0] gain_reg = GAIN_RESET;
  logic [POLE_W-1:0] pole_reg = POLE_RESET;
  int                mag_state = 0;
  longint            y_state = 0;

  pcm_word_t pcm_expected[$];
  int        error_count = 0;
  int        words_checked = 0;
  int        send_idle_pct = 33;
  int        recv_idle_pct = 66;

  // Random envelope generator state
  int                             env_amp = 0;
  logic signed [SAMPLE_WIDTH-1:0] last_i = '0;
  logic signed [SAMPLE_WIDTH-1:0] last_q = '0;

  am_envelope_dc_block_gain i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .i_sample     (i_sample),
    .q_sample     (q_sample),
    .block_end    (block_end),
    .pcm_valid    (pcm_valid),
    .pcm_ready    (pcm_ready),
    .pcm_sample   (pcm_sample),
    .pcm_block_end(pcm_block_end)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Abort the run if it hangs
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Envelope, DC blocker and gain for one I/Q pair; advances the filter state
  function automatic pcm_word_t demod_predict(input logic signed [SAMPLE_WIDTH-1:0] iv,
                                              input logic signed [SAMPLE_WIDTH-1:0] qv,
                                              input logic be);
    int                 ia;
    int                 qa;
    int                 mag;
    longint             y;
    logic signed [95:0] yw;
    logic signed [95:0] gw;
    logic signed [95:0] scaled;
    logic signed [95:0] t;
    pcm_word_t          w;
    ia = (iv < 0) ? -int'(iv) : int'(iv);
    qa = (qv < 0) ? -int'(qv) : int'(qv);
    // On a tie the I value counts as the smaller
    mag = (ia > qa) ? ia + (qa >> 1) : qa + (ia >> 1);
    // Feedback product floors, then the sum saturates to the state width
    y = longint'(mag - mag_state) * (longint'(1) <<< FRACTION_BITS)
        + ((longint'(pole_reg) * y_state) >>> POLE_FRAC);
    if (y > Y_MAX) y = Y_MAX;
    else if (y < Y_MIN) y = Y_MIN;
    mag_state = mag;
    y_state = y;
    // Gain stage truncates toward zero, then saturates to 16 bits
    yw = 96'(y);
    gw = $signed({72'd0, gain_reg});
    scaled = yw * gw;
    if (scaled < 0) t = -((-scaled) >>> OUT_SHIFT);
    else t = scaled >>> OUT_SHIFT;
    if (t > 32767) w.pcm = 16'sh7FFF;
    else if (t < -32768) w.pcm = 16'sh8000;
    else w.pcm = t[PCM_W-1:0];
    w.blk_end = be;
    return w;
  endfunction

  task automatic report_error(input string text);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", text);
  endtask

  // Offer one word after a random gap; called and returns at a falling edge
  task automatic send_word(input logic signed [SAMPLE_WIDTH-1:0] iv,
                           input logic signed [SAMPLE_WIDTH-1:0] qv,
                           input logic be);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    i_sample     <= iv;
    q_sample     <= qv;
    block_end    <= be;
    sample_valid <= 1'b1;
    pcm_expected.push_back(demod_predict(iv, qv, be));
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every expected word is out, then let it settle
  task automatic wait_for_drain();
    sample_valid <= 1'b0;
    while (pcm_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write; only issued while the block is idle
  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_GAIN: gain_reg = data[GAIN_W-1:0];
      REG_POLE: pole_reg = data[POLE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mix of slowly moving envelopes, held words, corner values, full-range and small noise
  task automatic gen_item(output logic signed [SAMPLE_WIDTH-1:0] iv,
                          output logic signed [SAMPLE_WIDTH-1:0] qv,
                          output logic be);
    int mode;
    int a;
    int b;
    logic [31:0] r;
    mode = $urandom_range(0, 9);
    r = $urandom();
    case (mode)
      0, 1, 2, 3: begin
        env_amp += int'($urandom_range(0, 2048)) - 1024;
        if (env_amp < 0) env_amp = 0;
        if (env_amp > 32767) env_amp = 32767;
        a = $urandom_range(0, env_amp);
        b = env_amp - a;
        iv = r[0] ? SAMPLE_WIDTH'(-a) : SAMPLE_WIDTH'(a);
        qv = r[1] ? SAMPLE_WIDTH'(-b) : SAMPLE_WIDTH'(b);
      end
      4, 5: begin
        iv = r[15:0];
        qv = r[31:16];
      end
      6, 7: begin
        iv = SAMPLE_WIDTH'(int'($urandom_range(0, 16)) - 8);
        qv = SAMPLE_WIDTH'(int'($urandom_range(0, 16)) - 8);
      end
      8: begin
        case (r[2:0])
          3'd0: iv = 16'sh8000;
          3'd1: iv = -16'sd32767;
          3'd2: iv = 16'sd32767;
          3'd3: iv = 16'sd1;
          3'd4: iv = -16'sd1;
          default: iv = 16'sd0;
        endcase
        case (r[5:3])
          3'd0: qv = 16'sh8000;
          3'd1: qv = -16'sd32767;
          3'd2: qv = 16'sd32767;
          3'd3: qv = 16'sd1;
          3'd4: qv = -16'sd1;
          default: qv = 16'sd0;
        endcase
      end
      default: begin
        // Repeat the last word so the filter only decays
        iv = last_i;
        qv = last_q;
      end
    endcase
    be = ($urandom_range(0, 15) == 0);
    last_i = iv;
    last_q = qv;
  endtask

  // Drive receiver back-pressure at the falling edge
  always @(negedge clk) begin
    pcm_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check each word taken from the output against the oldest prediction
  always @(posedge clk) begin : check_word
    pcm_word_t want;
    if (!rst && pcm_valid && pcm_ready) begin
      if (pcm_expected.size() == 0) begin
        report_error($sformatf("unexpected word: pcm_sample %0d block_end %b",
                               pcm_sample, pcm_block_end));
      end else begin
        want = pcm_expected.pop_front();
        if (pcm_sample !== want.pcm)
          report_error($sformatf("word %0d: pcm_sample expected %0d got %0d",
                                 words_checked, want.pcm, pcm_sample));
        if (pcm_block_end !== want.blk_end)
          report_error($sformatf("word %0d: pcm_block_end expected %b got %b",
                                 words_checked, want.blk_end, pcm_block_end));
      end
      words_checked++;
    end
  end

  // Magnitude corners under the reset coefficients
  task automatic test_magnitude_corners();
    send_word(16'sd0, 16'sd0, 1'b0);
    send_word(16'sd32767, 16'sd0, 1'b0);
    send_word(16'sd0, 16'sd32767, 1'b1);
    send_word(16'sh8000, 16'sh8000, 1'b0);
    send_word(16'sh8000, 16'sd32767, 1'b0);
    send_word(16'sd1000, -16'sd1000, 1'b1);
    send_word(-16'sd1000, 16'sd1000, 1'b0);
    send_word(-16'sd32767, 16'sd5, 1'b0);
    send_word(16'sd3, 16'sh8000, 1'b1);
    send_word(16'sd0, 16'sd0, 1'b0);
    send_word(16'sd0, 16'sd0, 1'b0);
    wait_for_drain();
  endtask

  // Zero, full-scale and unity-step gain
  task automatic test_gain_extremes();
    write_reg(REG_GAIN, 24'd0);
    send_word(16'sd32767, 16'sd32767, 1'b0);
    send_word(16'sd0, 16'sd0, 1'b1);
    wait_for_drain();
    write_reg(REG_GAIN, 24'hFFFFFF);
    send_word(16'sd32767, 16'sh8000, 1'b0);
    send_word(16'sd0, 16'sd0, 1'b0);
    wait_for_drain();
    write_reg(REG_GAIN, 24'd1);
    send_word(16'sd20000, 16'sd100, 1'b0);
    send_word(16'sd2, 16'sd1, 1'b1);
    wait_for_drain();
  endtask

  // Pole at zero (upper data bits set and dropped) and at its maximum
  task automatic test_pole_extremes();
    write_reg(REG_GAIN, 24'd256);
    write_reg(REG_POLE, 24'hFF8000);
    send_word(16'sd12000, -16'sd7000, 1'b0);
    send_word(16'sd12000, -16'sd7000, 1'b0);
    send_word(-16'sd50, 16'sd9, 1'b1);
    wait_for_drain();
    write_reg(REG_POLE, 24'h007FFF);
    send_word(16'sd30000, 16'sd30000, 1'b0);
    send_word(16'sd30000, 16'sd30000, 1'b0);
    send_word(16'sd0, 16'sd0, 1'b0);
    wait_for_drain();
  endtask

  // One random phase under one coefficient setting, with a drain halfway
  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input int n_items,
                                   input logic [CFG_DATA_W-1:0] gain_data,
                                   input logic [CFG_DATA_W-1:0] pole_data);
    logic signed [SAMPLE_WIDTH-1:0] iv;
    logic signed [SAMPLE_WIDTH-1:0] qv;
    logic                           be;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_reg(REG_GAIN, gain_data);
    write_reg(REG_POLE, pole_data);
    for (int n = 0; n < n_items; n++) begin
      if (n == n_items / 2) wait_for_drain();
      gen_item(iv, qv, be);
      send_word(iv, qv, be);
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_magnitude_corners();
    test_gain_extremes();
    test_pole_extremes();
    test_random_phase(33, 66, 500, 24'($urandom_range(0, 2048)), 24'($urandom()));
    test_random_phase(66, 33, 500, 24'($urandom()), 24'h007FFF);
    test_random_phase(0, 0, 500, GAIN_RESET, 24'(POLE_RESET));

    if (pcm_expected.size() != 0)
      report_error($sformatf("%0d expected words never arrived", pcm_expected.size()));

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
